// ----- rtl/smlist_pkg.sv -----
// Shared types and constants for the sorted multiset list.
// No dependencies; imported by every module of the block.
package smlist_pkg;

  localparam int unsigned CAPACITY = 16;
  localparam int unsigned CNT_W    = $clog2(CAPACITY + 1);
  localparam int unsigned VAL_W    = 32;
  localparam int unsigned OUT_W    = 5;

  typedef enum logic [1:0] {
    ACT_INSERT = 2'd0,
    ACT_SEARCH = 2'd1,
    ACT_REMOVE = 2'd2
  } action_e;

  typedef enum logic [2:0] {
    ST_INSERTED      = 3'd0,
    ST_FULL          = 3'd1,
    ST_EMPTY         = 3'd2,
    ST_FOUND         = 3'd3,
    ST_NOT_FOUND     = 3'd4,
    ST_REMOVED       = 3'd5,
    ST_REMOVED_EMPTY = 3'd6
  } status_e;

  typedef struct packed {
    logic [1:0]              action;
    logic signed [VAL_W-1:0] value;
  } req_t;

  typedef struct packed {
    logic [2:0]       status;
    logic [OUT_W-1:0] match_count;
    logic [OUT_W-1:0] occupancy;
  } rsp_t;

  // Broadcast from the controller to every cell of the chain.
  typedef struct packed {
    logic                    ins_en;
    logic                    rm_en;
    logic signed [VAL_W-1:0] value;
  } cell_ctl_t;

endpackage

// ----- rtl/smlist_cell.sv -----
// One slot of the sorted chain: holds a value, compares it with the request
// and keeps its own value or takes the request's, its left or its right neighbour's value. Uses smlist_pkg.
module smlist_cell import smlist_pkg::*; (
  input  logic                    clk_i,
  input  cell_ctl_t               ctl_i,
  input  logic                    valid_i,
  input  logic                    left_lt_i,
  input  logic signed [VAL_W-1:0] left_val_i,
  input  logic signed [VAL_W-1:0] right_val_i,
  output logic                    lt_o,
  output logic                    eq_o,
  output logic signed [VAL_W-1:0] val_o
);

  logic signed [VAL_W-1:0] val_q, val_d;

  assign lt_o  = valid_i && (val_q < ctl_i.value);
  assign eq_o  = valid_i && (val_q == ctl_i.value);
  assign val_o = val_q;

  // Slots at or past the insertion point move right; on removal they move left.
  always_comb begin
    val_d = val_q;
    if (ctl_i.ins_en && !lt_o) begin
      val_d = left_lt_i ? ctl_i.value : left_val_i;
    end else if (ctl_i.rm_en && !lt_o) begin
      val_d = right_val_i;
    end
  end

  always_ff @(posedge clk_i) begin
    val_q <= val_d;
  end

endmodule

// ----- rtl/sorted_multiset_list_top.sv -----
// Sorted multiset list: request in, one registered response out per request.
// Acceptance sets busy_q; the busy cycle then sets done_q and the response.
// No new request is taken while busy_o is high, during the compare-and-shift pass
// of the cell chain, which runs in the cycle after acceptance.
// Reset clears occupancy and control; slot contents stay undefined until
// written. The receiver cannot stall: done_o lasts one cycle.
module sorted_multiset_list_top import smlist_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic start_i,
  input  req_t req_i,
  output logic busy_o,
  output logic done_o,
  output rsp_t rsp_o
);

  req_t             req_q;
  logic             busy_q, busy_d;
  logic             done_q, done_d;
  rsp_t             rsp_q, rsp_d;
  logic [CNT_W-1:0] count_q, count_d;

  logic                    lt   [CAPACITY];
  logic                    eq   [CAPACITY];
  logic signed [VAL_W-1:0] vals [CAPACITY];

  cell_ctl_t        ctl;
  logic             any_eq;
  logic [CNT_W-1:0] eq_total;
  logic             full;
  logic             empty;

  assign full  = (count_q == CNT_W'(CAPACITY));
  assign empty = (count_q == '0);

  always_comb begin
    any_eq   = 1'b0;
    eq_total = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      any_eq   = any_eq | eq[i];
      eq_total = eq_total + CNT_W'(eq[i]);
    end
  end

  assign ctl.value  = req_q.value;
  assign ctl.ins_en = busy_q && (req_q.action == ACT_INSERT) && !full;
  assign ctl.rm_en  = busy_q && (req_q.action == ACT_REMOVE) && any_eq;

  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    logic                    left_lt;
    logic signed [VAL_W-1:0] left_val;
    logic signed [VAL_W-1:0] right_val;

    if (g == 0) begin : g_first
      assign left_lt  = 1'b1;
      assign left_val = req_q.value;
    end else begin : g_mid
      assign left_lt  = lt[g-1];
      assign left_val = vals[g-1];
    end
    if (g == CAPACITY - 1) begin : g_last
      assign right_val = vals[g];
    end else begin : g_inner
      assign right_val = vals[g+1];
    end

    smlist_cell u_cell (
      .clk_i       (clk_i),
      .ctl_i       (ctl),
      .valid_i     (count_q > CNT_W'(g)),
      .left_lt_i   (left_lt),
      .left_val_i  (left_val),
      .right_val_i (right_val),
      .lt_o        (lt[g]),
      .eq_o        (eq[g]),
      .val_o       (vals[g])
    );
  end

  always_comb begin
    busy_d            = busy_q;
    done_d            = 1'b0;
    count_d           = count_q;
    rsp_d             = rsp_q;
    rsp_d.match_count = '0;
    if (start_i && !busy_q) begin
      busy_d = 1'b1;
    end else if (busy_q) begin
      busy_d = 1'b0;
      done_d = 1'b1;
      unique case (req_q.action)
        ACT_INSERT: begin
          if (full) begin
            rsp_d.status = ST_FULL;
          end else begin
            rsp_d.status = ST_INSERTED;
            count_d      = count_q + CNT_W'(1);
          end
        end
        ACT_REMOVE: begin
          if (empty) begin
            rsp_d.status = ST_EMPTY;
          end else if (!any_eq) begin
            rsp_d.status = ST_NOT_FOUND;
          end else begin
            count_d      = count_q - CNT_W'(1);
            rsp_d.status = (count_q == CNT_W'(1)) ? ST_REMOVED_EMPTY : ST_REMOVED;
          end
        end
        default: begin
          // Search, and the spare code, which reads like a search.
          if (empty) begin
            rsp_d.status = ST_EMPTY;
          end else begin
            rsp_d.status      = any_eq ? ST_FOUND : ST_NOT_FOUND;
            rsp_d.match_count = OUT_W'(eq_total);
          end
        end
      endcase
      rsp_d.occupancy = OUT_W'(count_d);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q  <= 1'b0;
      done_q  <= 1'b0;
      count_q <= '0;
    end else begin
      busy_q  <= busy_d;
      done_q  <= done_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i && !busy_q) begin
      req_q <= req_i;
    end
    rsp_q <= rsp_d;
  end

  assign busy_o = busy_q;
  assign done_o = done_q;
  assign rsp_o  = rsp_q;

  a_busy_one_cycle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |=> (done_q && !busy_q))
    else $error("execute phase did not finish in one cycle");

  a_done_after_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> $past(busy_q))
    else $error("response without a preceding request");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(CAPACITY))
    else $error("occupancy beyond capacity");

  a_insert_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_q && rsp_q.status == ST_INSERTED) |-> (count_q == $past(count_q) + CNT_W'(1)))
    else $error("insert did not grow occupancy by one");

  a_shift_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(ctl.ins_en && ctl.rm_en))
    else $error("insert and remove shift at once");

endmodule
